// ===== hdl/llsc_pkg.sv =====
package llsc_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_BYTE  = 2'd2;

  localparam logic [1:0] CFG_CONNECT_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_SEND_PERIOD     = 2'd1;
  localparam logic [1:0] CFG_ATTEMPT_LIMIT   = 2'd2;

  localparam logic [1:0] ACT_NONE      = 2'd0;
  localparam logic [1:0] ACT_ESTABLISH = 2'd1;
  localparam logic [1:0] ACT_SEND      = 2'd2;
  localparam logic [1:0] ACT_TERMINATE = 2'd3;

  localparam logic [2:0] EVT_NONE            = 3'd0;
  localparam logic [2:0] EVT_CONNECT_TIMEOUT = 3'd1;
  localparam logic [2:0] EVT_SEND_TIMEOUT    = 3'd2;
  localparam logic [2:0] EVT_CONNECTED       = 3'd3;
  localparam logic [2:0] EVT_EXECUTED        = 3'd4;

  localparam logic [47:0] FRAME_UNLOCK = 48'h0C030501090D;
  localparam logic [47:0] FRAME_LOCK   = 48'h0C030500080D;

  localparam logic [7:0] RX_HEADER  = 8'h0C;
  localparam logic [7:0] ACK_CMD    = 8'h80;
  localparam logic [7:0] ACK_RESULT = 8'h05;

  localparam logic [7:0] RST_CONNECT_TIMEOUT = 8'd20;
  localparam logic [3:0] RST_SEND_PERIOD     = 4'd3;
  localparam logic [3:0] RST_ATTEMPT_LIMIT   = 4'd3;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_START,
    KIND_BYTE,
    KIND_NONE
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [47:0] peer_address;
    logic        unlock;
    logic        link_up;
    logic [7:0]  rx_byte;
    logic        rx_last;
  } item_t;

endpackage

// ===== hdl/llsc_front.sv =====
module llsc_front (
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           req_type_i,
  input  logic [47:0]          peer_address_i,
  input  logic                 unlock_i,
  input  logic                 link_up_i,
  input  logic [7:0]           rx_byte_i,
  input  logic                 rx_last_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output llsc_pkg::item_t      item_o
);

  llsc_pkg::kind_e kind;

  always_comb begin
    case (req_type_i)
      llsc_pkg::REQ_TICK:  kind = llsc_pkg::KIND_TICK;
      llsc_pkg::REQ_START: kind = llsc_pkg::KIND_START;
      llsc_pkg::REQ_BYTE:  kind = llsc_pkg::KIND_BYTE;
      default:             kind = llsc_pkg::KIND_NONE;
    endcase
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i & ~q_full_i;

  assign item_o.kind         = kind;
  assign item_o.peer_address = peer_address_i;
  assign item_o.unlock       = unlock_i;
  assign item_o.link_up      = link_up_i;
  assign item_o.rx_byte      = rx_byte_i;
  assign item_o.rx_last      = rx_last_i;

endmodule

// ===== hdl/llsc_queue.sv =====
module llsc_queue #(
  parameter int unsigned Depth = llsc_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  llsc_pkg::item_t item_i,
  input  logic            pop_i,
  output llsc_pkg::item_t item_o,
  output logic            full_o,
  output logic            empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  llsc_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== hdl/llsc_back.sv =====
module llsc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  input  logic [1:0]      cfg_index_i,
  input  logic [7:0]      cfg_data_i,
  input  logic            q_empty_i,
  input  llsc_pkg::item_t item_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [1:0]      action_o,
  output logic [47:0]     link_address_o,
  output logic [47:0]     command_frame_o,
  output logic [2:0]      event_res_o,
  output logic            frame_valid_o,
  output logic [1:0]      phase_o
);

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_CONNECT = 2'd1;
  localparam logic [1:0] PH_SEND    = 2'd2;

  logic [7:0]  conn_timeout_q;
  logic [3:0]  send_period_q;
  logic [3:0]  attempt_limit_q;

  logic [1:0]  phase_q, phase_d;
  logic        unlock_q, unlock_d;
  logic [7:0]  conn_ticks_q, conn_ticks_d;
  logic [3:0]  tick_phase_q, tick_phase_d;
  logic [4:0]  attempts_q, attempts_d;
  logic [7:0]  rx_count_q, rx_count_d;
  logic [7:0]  rx_length_q, rx_length_d;
  logic [7:0]  rx_sum_q, rx_sum_d;
  logic [1:0]  rx_flags_q, rx_flags_d;
  logic [7:0]  rx_cmd_q, rx_cmd_d;
  logic [7:0]  rx_pay_q, rx_pay_d;

  logic        out_valid_q, out_valid_d;
  logic [1:0]  action_q, action_d;
  logic [47:0] link_addr_q, link_addr_d;
  logic [47:0] frame_q, frame_d;
  logic [2:0]  event_q, event_d;
  logic        fvalid_q, fvalid_d;

  logic [3:0]  period;
  logic [4:0]  tick_inc;
  logic [7:0]  byte_in;
  logic [7:0]  len_new;
  logic        frame_ok;

  assign pop_o   = ~q_empty_i & (~out_valid_q | ~out_stall_i);
  assign period  = (send_period_q == 4'd0) ? 4'd1 : send_period_q;
  assign tick_inc = {1'b0, tick_phase_q} + 5'd1;
  assign byte_in = item_i.rx_byte;
  assign len_new = (rx_count_q == 8'd1) ? byte_in : rx_length_q;

  always_comb begin
    phase_d      = phase_q;
    unlock_d     = unlock_q;
    conn_ticks_d = conn_ticks_q;
    tick_phase_d = tick_phase_q;
    attempts_d   = attempts_q;
    rx_count_d   = rx_count_q;
    rx_length_d  = rx_length_q;
    rx_sum_d     = rx_sum_q;
    rx_flags_d   = rx_flags_q;
    rx_cmd_d     = rx_cmd_q;
    rx_pay_d     = rx_pay_q;
    action_d     = llsc_pkg::ACT_NONE;
    link_addr_d  = '0;
    frame_d      = '0;
    event_d      = llsc_pkg::EVT_NONE;
    fvalid_d     = 1'b0;
    frame_ok     = 1'b0;
    out_valid_d  = out_valid_q & out_stall_i;

    if (pop_o) begin
      out_valid_d = 1'b1;
      case (item_i.kind)
        llsc_pkg::KIND_TICK: begin
          case (phase_q)
            PH_IDLE: begin
              if (item_i.link_up) begin
                action_d = llsc_pkg::ACT_TERMINATE;
              end
            end
            PH_CONNECT: begin
              if (conn_ticks_q >= conn_timeout_q) begin
                conn_ticks_d = '0;
                phase_d      = PH_IDLE;
                event_d      = llsc_pkg::EVT_CONNECT_TIMEOUT;
              end else if (item_i.link_up) begin
                conn_ticks_d = '0;
                phase_d      = PH_SEND;
                event_d      = llsc_pkg::EVT_CONNECTED;
              end else begin
                conn_ticks_d = conn_ticks_q + 8'd1;
              end
            end
            PH_SEND: begin
              tick_phase_d = (tick_inc >= {1'b0, period}) ? 4'd0 : tick_inc[3:0];
              if (tick_phase_q == 4'd0) begin
                if (attempts_q > {1'b0, attempt_limit_q}) begin
                  attempts_d = '0;
                  phase_d    = PH_IDLE;
                  event_d    = llsc_pkg::EVT_SEND_TIMEOUT;
                end else begin
                  attempts_d = attempts_q + 5'd1;
                  action_d   = llsc_pkg::ACT_SEND;
                  frame_d    = unlock_q ? llsc_pkg::FRAME_UNLOCK : llsc_pkg::FRAME_LOCK;
                end
              end
            end
            default: begin
              phase_d = PH_IDLE;
            end
          endcase
        end
        llsc_pkg::KIND_START: begin
          action_d     = llsc_pkg::ACT_ESTABLISH;
          link_addr_d  = item_i.peer_address;
          phase_d      = PH_CONNECT;
          conn_ticks_d = '0;
          unlock_d     = item_i.unlock;
        end
        llsc_pkg::KIND_BYTE: begin
          if (rx_count_q == 8'd0) begin
            rx_flags_d = {1'b0, byte_in == llsc_pkg::RX_HEADER};
          end
          rx_length_d = len_new;
          if (rx_count_q != 8'd0 && {1'b0, rx_count_q} == {1'b0, len_new} + 9'd1
              && byte_in == rx_sum_q) begin
            rx_flags_d[1] = 1'b1;
          end
          if (rx_count_q != 8'd0 && rx_count_q <= len_new) begin
            rx_sum_d = rx_sum_q + byte_in;
          end
          if (rx_count_q == 8'd2) begin
            rx_cmd_d = byte_in;
          end
          if (rx_count_q == 8'd3) begin
            rx_pay_d = byte_in;
          end
          if (rx_count_q != 8'd255) begin
            rx_count_d = rx_count_q + 8'd1;
          end
          if (item_i.rx_last) begin
            frame_ok = (rx_count_q != 8'd255) && (rx_flags_d == 2'b11)
                       && ({2'b0, rx_count_q} + 10'd1 == {2'b0, len_new} + 10'd3);
            fvalid_d = frame_ok;
            if (frame_ok && rx_count_q >= 8'd3 && rx_cmd_d == llsc_pkg::ACK_CMD
                && rx_pay_d == llsc_pkg::ACK_RESULT) begin
              phase_d      = PH_IDLE;
              tick_phase_d = '0;
              attempts_d   = '0;
              event_d      = llsc_pkg::EVT_EXECUTED;
            end
            rx_count_d  = '0;
            rx_length_d = '0;
            rx_sum_d    = '0;
            rx_flags_d  = '0;
            rx_cmd_d    = '0;
            rx_pay_d    = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conn_timeout_q  <= llsc_pkg::RST_CONNECT_TIMEOUT;
      send_period_q   <= llsc_pkg::RST_SEND_PERIOD;
      attempt_limit_q <= llsc_pkg::RST_ATTEMPT_LIMIT;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        llsc_pkg::CFG_CONNECT_TIMEOUT: conn_timeout_q  <= cfg_data_i;
        llsc_pkg::CFG_SEND_PERIOD:     send_period_q   <= cfg_data_i[3:0];
        llsc_pkg::CFG_ATTEMPT_LIMIT:   attempt_limit_q <= cfg_data_i[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      unlock_q     <= 1'b0;
      conn_ticks_q <= '0;
      tick_phase_q <= '0;
      attempts_q   <= '0;
      rx_count_q   <= '0;
      rx_length_q  <= '0;
      rx_sum_q     <= '0;
      rx_flags_q   <= '0;
      rx_cmd_q     <= '0;
      rx_pay_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      unlock_q     <= unlock_d;
      conn_ticks_q <= conn_ticks_d;
      tick_phase_q <= tick_phase_d;
      attempts_q   <= attempts_d;
      rx_count_q   <= rx_count_d;
      rx_length_q  <= rx_length_d;
      rx_sum_q     <= rx_sum_d;
      rx_flags_q   <= rx_flags_d;
      rx_cmd_q     <= rx_cmd_d;
      rx_pay_q     <= rx_pay_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      action_q    <= action_d;
      link_addr_q <= link_addr_d;
      frame_q     <= frame_d;
      event_q     <= event_d;
      fvalid_q    <= fvalid_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign action_o        = action_q;
  assign link_address_o  = link_addr_q;
  assign command_frame_o = frame_q;
  assign event_res_o     = event_q;
  assign frame_valid_o   = fvalid_q;
  assign phase_o         = phase_q;

endmodule

// ===== hdl/lock_link_session_controller_unit.sv =====
// Lock/unlock session controller: takes ticks, start requests and received
// frame bytes, one per beat, and answers every beat with exactly one result
// (link action, command frame, session event, frame check and current phase).
// A front stage decodes each beat into a small queue, and a back stage runs
// the session state and frame checker and holds the result in an output
// register. It sustains one beat per clock while the output is not stalled; a beat
// is registered in the queue and then its result in the output register, and the
// queue lets input flow on while a result waits, until it fills. The cfg port writes
// registers (index: connect timeout, send period, attempt limit); the user must do so
// only while no beat is in flight, which is not enforced. cfg_ready_o is always high.
module lock_link_session_controller_unit #(
  parameter int unsigned QueueDepth = llsc_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [47:0] peer_address_i,
  input  logic        unlock_i,
  input  logic        link_up_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        rx_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  action_o,
  output logic [47:0] link_address_o,
  output logic [47:0] command_frame_o,
  output logic [2:0]  event_res_o,
  output logic        frame_valid_o,
  output logic [1:0]  phase_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  llsc_pkg::item_t front_item;
  llsc_pkg::item_t back_item;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;

  assign cfg_ready_o = 1'b1;

  llsc_front u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .peer_address_i (peer_address_i),
    .unlock_i       (unlock_i),
    .link_up_i      (link_up_i),
    .rx_byte_i      (rx_byte_i),
    .rx_last_i      (rx_last_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .item_o         (front_item)
  );

  llsc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .item_o  (back_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  llsc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i & cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .q_empty_i       (q_empty),
    .item_i          (back_item),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .action_o        (action_o),
    .link_address_o  (link_address_o),
    .command_frame_o (command_frame_o),
    .event_res_o     (event_res_o),
    .frame_valid_o   (frame_valid_o),
    .phase_o         (phase_o)
  );

endmodule
